>>> rtl/kgd_pkg.sv
// ----------------------------------------------------------------------------
// kgd_pkg
// shared types and constants of the key gesture detector
// ----------------------------------------------------------------------------
package kgd_pkg;

	localparam int NUM_KEYS    = 4;
	localparam int MAX_RESULTS = 3;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [15:0] DOUBLE_WAIT_RST = 16'd300;
	localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
	localparam logic [15:0] REPEAT_RST      = 16'd200;

	// register indexes
	localparam logic [1:0] REG_DOUBLE_WAIT = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS  = 2'd1;
	localparam logic [1:0] REG_REPEAT      = 2'd2;

	// gesture codes
	localparam logic [1:0] G_SINGLE = 2'd0;
	localparam logic [1:0] G_DOUBLE = 2'd1;
	localparam logic [1:0] G_LONG   = 2'd2;
	localparam logic [1:0] G_REPEAT = 2'd3;

	typedef struct packed {
		logic [15:0] double_wait;
		logic [15:0] long_press;
		logic [15:0] rpt;
	} cfg_t;

	typedef struct packed {
		logic [1:0] key_index;
		logic [1:0] gesture;
	} res_t;

	// all results caused by one request
	typedef struct packed {
		logic [1:0]                  cnt;
		res_t [MAX_RESULTS-1:0]      res;
	} bundle_t;

endpackage

>>> rtl/key_gesture_detector.sv
// ----------------------------------------------------------------------------
// key_gesture_detector
// click, double click, long press and repeat detection for up to four keys
// ----------------------------------------------------------------------------
// requests arrive on in_valid/in_stall: kind 0 is a key event, kind 1 a
// one-millisecond tick. the front updates key and timer state in the cycle a
// request is taken and queues the gestures it causes (none to three).
// the back drains the queue one gesture per cycle while out_stall is low,
// onto out_valid/out_stall; last marks the final gesture of a request.
// throughput: one request per cycle while the two-entry queue has room; the
// single output register sets the drain rate, so the gestures of a tick
// leave it one after another. while out_stall is high the output holds and
// the queue fills, then in_stall rises until space frees up.
// reset clears all key state, timers and the queue and restores the register
// defaults 300, 1000 and 200 ticks. registers sit at 0x0, 0x4, 0x8 of the
// apb port and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module key_gesture_detector import kgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [4:0]  event_type,
	input  logic [9:0]  key_code,
	input  logic [1:0]  key_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  key_index,
	output logic [1:0]  gesture,
	output logic        last
);

	cfg_t    cfg_q;
	logic    wr;
	logic    acc;
	logic    push, pop, full, empty;
	bundle_t wbun, head;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.double_wait <= DOUBLE_WAIT_RST;
			cfg_q.long_press  <= LONG_PRESS_RST;
			cfg_q.rpt         <= REPEAT_RST;
		end else if (wr) begin
			case (paddr[3:2])
				REG_DOUBLE_WAIT: cfg_q.double_wait <= pwdata[15:0];
				REG_LONG_PRESS:  cfg_q.long_press  <= pwdata[15:0];
				REG_REPEAT:      cfg_q.rpt         <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DOUBLE_WAIT: prdata = {16'd0, cfg_q.double_wait};
			REG_LONG_PRESS:  prdata = {16'd0, cfg_q.long_press};
			REG_REPEAT:      prdata = {16'd0, cfg_q.rpt};
			default:         prdata = 32'd0;
		endcase
	end

	assign in_stall = full;
	assign acc      = in_valid && !in_stall;

	kgd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.acc        (acc),
		.kind       (kind),
		.event_type (event_type),
		.key_code   (key_code),
		.key_value  (key_value),
		.push       (push),
		.bundle     (wbun)
	);

	kgd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wbun),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	kgd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.key_index (key_index),
		.gesture   (gesture),
		.last      (last)
	);

endmodule

>>> rtl/kgd_front.sv
// ----------------------------------------------------------------------------
// kgd_front
// decodes requests, runs the per-key press state and the three shared timers
// ----------------------------------------------------------------------------
module kgd_front import kgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        acc,
	input  logic        kind,
	input  logic [4:0]  event_type,
	input  logic [9:0]  key_code,
	input  logic [1:0]  key_value,
	output logic        push,
	output bundle_t     bundle
);

	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_WAIT_REL = 2'd1,
		ST_WAIT_DBL = 2'd2,
		ST_REPEAT   = 2'd3
	} press_t;

	localparam logic [4:0] EV_KEY = 5'd1;

	press_t      ps_q [4];
	logic [3:0]  held_q;
	logic        dp_q, lp_q, rp_q;
	logic [15:0] dc_q, lc_q, rc_q;
	logic [1:0]  dk_q, lk_q, rk_q;

	press_t      ps_n [4];
	logic [3:0]  held_n;
	logic        dp_n, lp_n, rp_n;
	logic [15:0] dc_n, lc_n, rc_n;
	logic [1:0]  dk_n, lk_n, rk_n;

	logic        d_exp, l_exp, r_exp;
	logic [1:0]  k;
	logic        hit;
	logic        press;
	logic [1:0]  n;
	res_t [MAX_RESULTS-1:0] res;
	logic [15:0] ld_double, ld_long, ld_rpt;

	assign ld_double = (cfg.double_wait == 16'd0) ? 16'd1 : cfg.double_wait;
	assign ld_long   = (cfg.long_press == 16'd0) ? 16'd1 : cfg.long_press;
	assign ld_rpt    = (cfg.rpt == 16'd0) ? 16'd1 : cfg.rpt;

	always_comb begin
		hit = 1'b1;
		k   = 2'd0;
		case (key_code)
			10'd11:  k = 2'd0;
			10'd2:   k = 2'd1;
			10'd3:   k = 2'd2;
			10'd4:   k = 2'd3;
			default: hit = 1'b0;
		endcase
		if (32'(k) >= NUM_KEYS) hit = 1'b0;
	end

	assign press = (key_value == 2'd1);

	always_comb begin
		ps_n   = ps_q;
		held_n = held_q;
		dp_n = dp_q; lp_n = lp_q; rp_n = rp_q;
		dc_n = dc_q; lc_n = lc_q; rc_n = rc_q;
		dk_n = dk_q; lk_n = lk_q; rk_n = rk_q;
		d_exp = 1'b0; l_exp = 1'b0; r_exp = 1'b0;
		n   = 2'd0;
		res = '0;
		if (acc && kind) begin
			if (dp_q) begin
				if (dc_n != 16'd0) dc_n = dc_n - 16'd1;
				d_exp = (dc_n == 16'd0);
			end
			if (lp_q) begin
				if (lc_n != 16'd0) lc_n = lc_n - 16'd1;
				l_exp = (lc_n == 16'd0);
			end
			if (rp_q) begin
				if (rc_n != 16'd0) rc_n = rc_n - 16'd1;
				r_exp = (rc_n == 16'd0);
			end
			if (d_exp) begin
				dp_n = 1'b0;
				if (ps_n[dk_n] == ST_WAIT_DBL) begin
					res[n] = '{key_index: dk_n, gesture: G_SINGLE};
					n = n + 2'd1;
					ps_n[dk_n] = ST_IDLE;
				end
			end
			if (l_exp) begin
				lp_n = 1'b0;
				if (ps_n[lk_n] == ST_WAIT_REL && held_n[lk_n]) begin
					res[n] = '{key_index: lk_n, gesture: G_LONG};
					n = n + 2'd1;
					ps_n[lk_n] = ST_REPEAT;
					rk_n = lk_n;
					// an expired repeat timer still counts as pending here
					if (!rp_n) begin
						rp_n = 1'b1;
						rc_n = ld_rpt;
					end
				end
			end
			if (r_exp) begin
				rp_n = 1'b0;
				if (ps_n[rk_n] == ST_REPEAT && held_n[rk_n]) begin
					res[n] = '{key_index: rk_n, gesture: G_REPEAT};
					n = n + 2'd1;
					rp_n = 1'b1;
					rc_n = ld_rpt;
				end
			end
		end else if (acc && event_type == EV_KEY && hit) begin
			held_n[k] = press;
			if (press) begin
				if (ps_q[k] == ST_IDLE) begin
					ps_n[k] = ST_WAIT_REL;
					lk_n = k;
					if (!lp_q) begin
						lp_n = 1'b1;
						lc_n = ld_long;
					end
				end else if (ps_q[k] == ST_WAIT_DBL) begin
					// cancels the double timer whatever key it serves
					dp_n = 1'b0;
					ps_n[k] = ST_IDLE;
					res[0] = '{key_index: k, gesture: G_DOUBLE};
					n = 2'd1;
				end
			end else begin
				if (ps_q[k] == ST_WAIT_REL) begin
					lp_n = 1'b0;
					ps_n[k] = ST_WAIT_DBL;
					dk_n = k;
					if (!dp_q) begin
						dp_n = 1'b1;
						dc_n = ld_double;
					end
				end else if (ps_q[k] == ST_REPEAT) begin
					rp_n = 1'b0;
					ps_n[k] = ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) ps_q[i] <= ST_IDLE;
			held_q <= '0;
			dp_q <= 1'b0; lp_q <= 1'b0; rp_q <= 1'b0;
			dc_q <= '0; lc_q <= '0; rc_q <= '0;
			dk_q <= '0; lk_q <= '0; rk_q <= '0;
		end else begin
			ps_q   <= ps_n;
			held_q <= held_n;
			dp_q <= dp_n; lp_q <= lp_n; rp_q <= rp_n;
			dc_q <= dc_n; lc_q <= lc_n; rc_q <= rc_n;
			dk_q <= dk_n; lk_q <= lk_n; rk_q <= rk_n;
		end
	end

	assign push       = (n != 2'd0);
	assign bundle.cnt = n;
	assign bundle.res = res;

endmodule

>>> rtl/kgd_queue.sv
// ----------------------------------------------------------------------------
// kgd_queue
// short queue of result bundles between the front and the back
// ----------------------------------------------------------------------------
module kgd_queue import kgd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wdata,
	input  logic    pop,
	output bundle_t rdata,
	output logic    full,
	output logic    empty
);

	bundle_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wp_q, rp_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_push, do_pop;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= (wp_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_pop)
				rp_q <= (rp_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
		end
	end

endmodule

>>> rtl/kgd_back.sv
// ----------------------------------------------------------------------------
// kgd_back
// drains bundles one result per cycle, while out_stall is low, into the output register
// ----------------------------------------------------------------------------
module kgd_back import kgd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bundle_t    head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] key_index,
	output logic [1:0] gesture,
	output logic       last
);

	logic [1:0] idx_q;
	logic       vld_q;
	logic       take, fin;
	res_t       cur;

	assign take = !empty && (!vld_q || !out_stall);
	assign fin  = (idx_q == head.cnt - 2'd1);
	assign pop  = take && fin;
	assign cur  = head.res[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (take) begin
				vld_q <= 1'b1;
				idx_q <= fin ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_index <= cur.key_index;
			gesture   <= cur.gesture;
			last      <= fin;
		end
	end

	assign out_valid = vld_q;

endmodule

>>> sim/tb_key_gesture_detector.sv
// ----------------------------------------------------------------------------
// tb_key_gesture_detector
// self-checking testbench for the key gesture detector
// ----------------------------------------------------------------------------
// key events and millisecond ticks go in as requests on in_valid/in_stall
// the scoreboard models the key state machines and the three shared timers
// and checks the predicted gestures in order on out_valid/out_stall
// directed sequence first: ignored events, single, double, long, repeat and
// several gestures on one tick, then random requests under timer settings
// of 1, 0, 65535 ticks and random small values
// ----------------------------------------------------------------------------
module tb_key_gesture_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import kgd_pkg::*;

	localparam logic       KIND_EVENT   = 1'b0;
	localparam logic       KIND_TICK    = 1'b1;
	localparam logic [4:0] EV_KEY       = 5'd1;
	localparam logic [1:0] VAL_PRESSED  = 2'd1;
	localparam logic [9:0] KEY0_CODE    = 10'd11;
	localparam logic [9:0] KEY1_CODE    = 10'd2;
	localparam logic [9:0] KEY2_CODE    = 10'd3;
	localparam logic [9:0] KEY3_CODE    = 10'd4;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         END_CYCLES    = 20;
	localparam int         QUIET_LIMIT   = 2000;
	localparam int         REPORT_LIMIT  = 10;

	typedef enum logic [1:0] {
		KEY_IDLE,
		KEY_WAIT_RELEASE,
		KEY_WAIT_DOUBLE,
		KEY_REPEATING
	} key_phase_t;

	typedef enum int {TMR_DOUBLE = 0, TMR_LONG = 1, TMR_REPEAT = 2} timer_sel_t;

	typedef struct {
		bit          armed;
		logic [15:0] count;
		logic [1:0]  owner;
	} timer_t;

	typedef struct {
		logic [1:0] key_index;
		logic [1:0] gesture;
		logic       last;
	} gesture_t;

	class gesture_scoreboard;
		logic [15:0] period[3];
		key_phase_t  phase[NUM_KEYS];
		bit          held[NUM_KEYS];
		timer_t      tmr[3];
		gesture_t    burst[$];
		gesture_t    due_gestures[$];
		int          n_requests;
		int          n_ticks;
		int          n_gestures;
		int          errors;

		function new();
			period[TMR_DOUBLE] = DOUBLE_WAIT_RST;
			period[TMR_LONG]   = LONG_PRESS_RST;
			period[TMR_REPEAT] = REPEAT_RST;
			foreach (phase[i]) begin
				phase[i] = KEY_IDLE;
				held[i]  = 1'b0;
			end
			foreach (tmr[i]) begin
				tmr[i].armed = 1'b0;
				tmr[i].count = '0;
				tmr[i].owner = '0;
			end
		endfunction

		function void set_register(logic [1:0] idx, logic [15:0] value);
			case (idx)
				REG_DOUBLE_WAIT: period[TMR_DOUBLE] = value;
				REG_LONG_PRESS:  period[TMR_LONG]   = value;
				REG_REPEAT:      period[TMR_REPEAT] = value;
				default: ;
			endcase
		endfunction

		// a running timer keeps its count, only its owner moves
		function void arm(timer_sel_t t);
			if (!tmr[t].armed) begin
				tmr[t].armed = 1'b1;
				tmr[t].count = (period[t] == 16'd0) ? 16'd1 : period[t];
			end
		endfunction

		function void emit(logic [1:0] k, logic [1:0] g);
			gesture_t rec;
			rec.key_index = k;
			rec.gesture   = g;
			rec.last      = 1'b0;
			burst.push_back(rec);
		endfunction

		function void run_tick();
			bit         fired[3];
			logic [1:0] k;
			foreach (tmr[i]) begin
				fired[i] = 1'b0;
				if (tmr[i].armed) begin
					if (tmr[i].count != 16'd0)
						tmr[i].count = tmr[i].count - 16'd1;
					fired[i] = (tmr[i].count == 16'd0);
				end
			end
			if (fired[TMR_DOUBLE]) begin
				tmr[TMR_DOUBLE].armed = 1'b0;
				k = tmr[TMR_DOUBLE].owner;
				if (phase[k] == KEY_WAIT_DOUBLE) begin
					emit(k, G_SINGLE);
					phase[k] = KEY_IDLE;
				end
			end
			if (fired[TMR_LONG]) begin
				tmr[TMR_LONG].armed = 1'b0;
				k = tmr[TMR_LONG].owner;
				if (phase[k] == KEY_WAIT_RELEASE && held[k]) begin
					emit(k, G_LONG);
					phase[k] = KEY_REPEATING;
					tmr[TMR_REPEAT].owner = k;
					arm(TMR_REPEAT);
				end
			end
			// an expired repeat timer is still armed, the long handler only retargets it
			if (fired[TMR_REPEAT]) begin
				tmr[TMR_REPEAT].armed = 1'b0;
				k = tmr[TMR_REPEAT].owner;
				if (phase[k] == KEY_REPEATING && held[k]) begin
					emit(k, G_REPEAT);
					arm(TMR_REPEAT);
				end
			end
		endfunction

		function void run_event(logic [4:0] t, logic [9:0] c, logic [1:0] v);
			logic [1:0] k;
			bit         down;
			if (t != EV_KEY)
				return;
			case (c)
				KEY0_CODE: k = 2'd0;
				KEY1_CODE: k = 2'd1;
				KEY2_CODE: k = 2'd2;
				KEY3_CODE: k = 2'd3;
				default: return;
			endcase
			if (k >= NUM_KEYS)
				return;
			down = (v == VAL_PRESSED);
			held[k] = down;
			if (down) begin
				if (phase[k] == KEY_IDLE) begin
					phase[k] = KEY_WAIT_RELEASE;
					tmr[TMR_LONG].owner = k;
					arm(TMR_LONG);
				end else if (phase[k] == KEY_WAIT_DOUBLE) begin
					// cancels the double timer whichever key it serves
					tmr[TMR_DOUBLE].armed = 1'b0;
					phase[k] = KEY_IDLE;
					emit(k, G_DOUBLE);
				end
			end else begin
				if (phase[k] == KEY_WAIT_RELEASE) begin
					tmr[TMR_LONG].armed = 1'b0;
					phase[k] = KEY_WAIT_DOUBLE;
					tmr[TMR_DOUBLE].owner = k;
					arm(TMR_DOUBLE);
				end else if (phase[k] == KEY_REPEATING) begin
					tmr[TMR_REPEAT].armed = 1'b0;
					phase[k] = KEY_IDLE;
				end
			end
		endfunction

		function void predict_gestures(logic k, logic [4:0] t, logic [9:0] c,
				logic [1:0] v);
			burst.delete();
			n_requests++;
			if (k == KIND_TICK) begin
				n_ticks++;
				run_tick();
			end else begin
				run_event(t, c, v);
			end
			if (burst.size() > 0)
				burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i])
				due_gestures.push_back(burst[i]);
			n_gestures += burst.size();
		endfunction

		function void check_gesture(logic [1:0] k, logic [1:0] g, logic l);
			gesture_t want;
			if (due_gestures.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t unexpected gesture: key %0d gesture %0d last %0b",
						$realtime, k, g, l);
				return;
			end
			want = due_gestures.pop_front();
			if (k !== want.key_index || g !== want.gesture || l !== want.last) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display({"%0t gesture mismatch: expected key %0d gesture %0d last %0b,",
						" got key %0d gesture %0d last %0b"},
						$realtime, want.key_index, want.gesture, want.last, k, g, l);
			end
		endfunction

		function void close_out();
			if (due_gestures.size() != 0) begin
				errors += due_gestures.size();
				$display("%0d expected gestures never arrived", due_gestures.size());
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [4:0]  event_type;
	logic [9:0]  key_code;
	logic [1:0]  key_value;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  key_index;
	logic [1:0]  gesture;
	logic        last;

	gesture_scoreboard sb = new();
	bit                idle_enable = 1'b0;
	int                n_settings  = 0;

	logic [9:0] key_codes[NUM_KEYS] = '{KEY0_CODE, KEY1_CODE, KEY2_CODE, KEY3_CODE};

	wire req_fire = in_valid && !in_stall;
	wire res_fire = out_valid && !out_stall;

	key_gesture_detector uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.event_type (event_type),
		.key_code   (key_code),
		.key_value  (key_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_index  (key_index),
		.gesture    (gesture),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_fire)
				sb.predict_gestures(kind, event_type, key_code, key_value);
			if (res_fire)
				sb.check_gesture(key_index, gesture, last);
		end
	end

	initial begin : sink_stall
		int hold;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_enable && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 10);
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
				out_stall = 1'b0;
			end else if ($urandom_range(0, 19) == 0) begin
				// free-running stretch
				hold = $urandom_range(10, 30);
				repeat (hold) @(negedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n && !req_fire && !res_fire)
				quiet++;
			else
				quiet = 0;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_request(input logic k, input logic [4:0] t, input logic [9:0] c,
			input logic [1:0] v);
		int gap;
		@(negedge clk);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind       = k;
		event_type = t;
		key_code   = c;
		key_value  = v;
		in_valid   = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic tick();
		send_request(KIND_TICK, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)),
			2'($urandom_range(0, 3)));
	endtask

	task automatic send_key(input logic [9:0] c, input logic [1:0] v);
		send_request(KIND_EVENT, EV_KEY, c, v);
	endtask

	task automatic send_random();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			tick();
		else if (pick < 88)
			send_key(key_codes[$urandom_range(0, NUM_KEYS - 1)],
				$urandom_range(0, 1) ? VAL_PRESSED : 2'($urandom_range(0, 3)));
		else
			send_request(KIND_EVENT, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)),
				2'($urandom_range(0, 3)));
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
		logic [15:0] upper;
		upper = $urandom_range(0, 65535);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = {upper, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(idx, value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// registers change only once the block has drained
	task automatic set_timing(input logic [15:0] dbl, input logic [15:0] lng,
			input logic [15:0] rpt);
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.due_gestures.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(REG_DOUBLE_WAIT, dbl);
		apb_write(REG_LONG_PRESS, lng);
		apb_write(REG_REPEAT, rpt);
		n_settings++;
	endtask

	initial begin : stimulus
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		kind       = KIND_EVENT;
		event_type = '0;
		key_code   = '0;
		key_value  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_enable = 1'b1;

		set_timing(16'd2, 16'd2, 16'd1);
		// ignored: wrong class, unmapped code
		send_request(KIND_EVENT, 5'd0, KEY0_CODE, VAL_PRESSED);
		send_request(KIND_EVENT, 5'd31, 10'd1023, 2'd3);
		send_key(10'd5, VAL_PRESSED);
		// short click then second press: double
		send_key(KEY0_CODE, VAL_PRESSED);
		send_key(KEY0_CODE, 2'd0);
		send_key(KEY0_CODE, VAL_PRESSED);
		// hold through long press and one repeat
		send_key(KEY1_CODE, VAL_PRESSED);
		tick();
		tick();
		tick();
		send_key(KEY1_CODE, 2'd3);
		// single on one key and long on another in the same tick, then a repeat
		send_key(KEY2_CODE, VAL_PRESSED);
		send_key(KEY2_CODE, 2'd2);
		send_key(KEY3_CODE, VAL_PRESSED);
		tick();
		tick();
		tick();
		send_key(KEY3_CODE, 2'd0);

		set_timing(16'd1, 16'd1, 16'd1);
		repeat (15) send_random();
		// zero behaves as one tick
		set_timing(16'd0, 16'd0, 16'd0);
		repeat (12) send_random();
		for (int p = 0; p < 4; p++) begin
			set_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
				16'($urandom_range(1, 6)));
			repeat (15) send_random();
		end

		idle_enable = 1'b0;
		set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (12) send_random();

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.due_gestures.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		sb.close_out();

		$display("%0d requests (%0d ticks) under %0d timing settings, %0d gestures checked",
			sb.n_requests, sb.n_ticks, n_settings, sb.n_gestures);
		$display("%0d mismatches", sb.errors);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
